[hw/rtl/salr_pkg.sv]
package salr_pkg;

   localparam int DEF_NUM_SETS   = 2048;
   localparam int DEF_NUM_WAYS   = 16;
   localparam int DEF_REUSE_BITS = 8;

   localparam int SET_IDX_W = 11;
   localparam int WAY_IDX_W = 4;

   localparam logic CMD_VICTIM = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   typedef struct packed {
      logic                 is_update;
      logic                 was_hit;
      logic [WAY_IDX_W-1:0] way;
   } salr_op_type;

endpackage

[hw/rtl/salr_row_ram.sv]
module salr_row_ram #(
   parameter int DEPTH = salr_pkg::DEF_NUM_SETS,
   parameter int WIDTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/salr_set_map.sv]
module salr_set_map #(
   parameter int NUM_SETS = salr_pkg::DEF_NUM_SETS
) (
   input  logic                                         clock,
   input  logic                                         load,
   input  logic [salr_pkg::SET_IDX_W-1:0]               set_raw,
   output logic [$clog2(NUM_SETS > 1 ? NUM_SETS : 2)-1:0] set_idx
);
   import salr_pkg::*;

   localparam int  SW = $clog2(NUM_SETS > 1 ? NUM_SETS : 2);
   localparam bit  MAP_DIRECT = (NUM_SETS >= (1 << SET_IDX_W))
                                || ((NUM_SETS & (NUM_SETS - 1)) == 0);

   generate
      if (MAP_DIRECT) begin : g_direct
         // power of two (or no wrap at all): plain mask, same cycle
         localparam logic [SW-1:0] DIRECT_MASK =
            (NUM_SETS >= (1 << SET_IDX_W)) ? {SW{1'b1}} : SW'(NUM_SETS - 1);
         assign set_idx = SW'(set_raw) & DIRECT_MASK;
      end else begin : g_recip
         // q = floor(x * floor(2^22 / N) / 2^22) is q_true or q_true - 1,
         // so one conditional subtract finishes the remainder
         localparam int      FRAC  = 2 * SET_IDX_W;
         localparam int      PRODW = 3 * SET_IDX_W;
         localparam longint  RECIP = (longint'(1) << FRAC) / NUM_SETS;

         logic [SET_IDX_W-1:0] x_ff, x_in, q_ff, q_in;
         logic [PRODW-1:0]     prod;
         logic [SET_IDX_W:0]   qn, rem, rem_fix;

         always_comb begin
            prod = PRODW'(set_raw) * PRODW'(RECIP);
            x_in = load ? set_raw : x_ff;
            q_in = load ? prod[FRAC +: SET_IDX_W] : q_ff;
         end

         always_ff @(posedge clock) begin
            x_ff <= x_in;
            q_ff <= q_in;
         end

         always_comb begin
            qn      = (SET_IDX_W + 1)'(q_ff * NUM_SETS);
            rem     = {1'b0, x_ff} - qn;
            rem_fix = (rem >= (SET_IDX_W + 1)'(NUM_SETS))
                      ? rem - (SET_IDX_W + 1)'(NUM_SETS) : rem;
            set_idx = SW'(rem_fix);
         end
      end
   endgenerate

endmodule

[hw/rtl/salr_row_logic.sv]
module salr_row_logic #(
   parameter int NUM_WAYS   = salr_pkg::DEF_NUM_WAYS,
   parameter int REUSE_BITS = salr_pkg::DEF_REUSE_BITS
) (
   input  logic [NUM_WAYS*($clog2(NUM_WAYS)+REUSE_BITS)-1:0] row_rd,
   input  salr_pkg::salr_op_type                             op,
   output logic [NUM_WAYS*($clog2(NUM_WAYS)+REUSE_BITS)-1:0] row_wr,
   output logic                                              upd_ok,
   output logic [salr_pkg::WAY_IDX_W-1:0]                    victim
);
   import salr_pkg::*;

   localparam int PW = $clog2(NUM_WAYS);

   logic [NUM_WAYS-1:0][PW-1:0]         pos, pos_new;
   logic [NUM_WAYS-1:0][REUSE_BITS-1:0] cnt, cnt_new;
   logic [PW-1:0]                       wsel, own;

   assign pos = row_rd[NUM_WAYS*PW-1:0];
   assign cnt = row_rd[NUM_WAYS*(PW+REUSE_BITS)-1:NUM_WAYS*PW];

   // positions always form a permutation, so exactly one way sits at the
   // oldest position and no reuse tie-break is needed
   always_comb begin
      victim = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (pos[w] == PW'(NUM_WAYS - 1)) begin
            victim = WAY_IDX_W'(w);
         end
      end
   end

   always_comb begin
      upd_ok = (32'(op.way) < NUM_WAYS);
      wsel   = PW'(op.way);
      own    = pos[wsel];
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (PW'(w) == wsel) begin
            pos_new[w] = '0;
            if (!op.was_hit) begin
               cnt_new[w] = '0;
            end else if (cnt[w] == {REUSE_BITS{1'b1}}) begin
               cnt_new[w] = cnt[w];
            end else begin
               cnt_new[w] = cnt[w] + 1'b1;
            end
         end else begin
            pos_new[w] = (pos[w] < own) ? pos[w] + 1'b1 : pos[w];
            cnt_new[w] = cnt[w];
         end
      end
      row_wr = {cnt_new, pos_new};
   end

endmodule

[hw/rtl/set_assoc_lru_reuse_replacement.sv]
// channel | words                                       | handshake
// req     | command, set_index, way_index, was_hit      | req_valid / req_ready
// rsp     | victim_way (victim requests only)           | rsp_valid / rsp_ready
//
// Each set is one row in a single-port-read, single-port-write RAM.
// An item reads its row, then compares or ages and writes back. The row
// is read at acceptance, but a set count that is not a power of two (below
// 2048) puts a map state for the set remainder first. Items are handled one at a time.
// After reset a clearing pass writes every row, with req_ready low. A
// victim word waiting on rsp_ready holds the next victim request in its
// execute state; the input side still accepts while a word waits.
module set_assoc_lru_reuse_replacement #(
   parameter int NUM_SETS   = salr_pkg::DEF_NUM_SETS,
   parameter int NUM_WAYS   = salr_pkg::DEF_NUM_WAYS,
   parameter int REUSE_BITS = salr_pkg::DEF_REUSE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [salr_pkg::SET_IDX_W-1:0] req_set_index,
   input  logic [salr_pkg::WAY_IDX_W-1:0] req_way_index,
   input  logic                           req_was_hit,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [salr_pkg::WAY_IDX_W-1:0] rsp_victim_way
);
   import salr_pkg::*;

   localparam int PW    = $clog2(NUM_WAYS);
   localparam int ROW_W = NUM_WAYS * (PW + REUSE_BITS);
   localparam int SW    = $clog2(NUM_SETS > 1 ? NUM_SETS : 2);
   localparam bit MAP_DIRECT = (NUM_SETS >= (1 << SET_IDX_W))
                               || ((NUM_SETS & (NUM_SETS - 1)) == 0);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_MAP, ST_EXEC} state_type;

   state_type            state_ff, state_in;
   logic [SW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [SW-1:0]        set_ff, set_in;
   salr_op_type          op_ff, op_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WAY_IDX_W-1:0] victim_ff, victim_in;

   logic                 accept, rsp_busy;
   logic [SW-1:0]        set_idx;
   logic                 ram_we, ram_rd_en;
   logic [SW-1:0]        ram_wr_addr;
   logic [ROW_W-1:0]     ram_wr_data, row_rd, row_wr, init_row;
   logic                 upd_ok;
   logic [WAY_IDX_W-1:0] victim;
   logic [NUM_WAYS-1:0][PW-1:0] init_pos;

   assign accept   = req_valid & req_ready;
   assign rsp_busy = rsp_valid_ff & ~rsp_ready;

   salr_set_map #(
      .NUM_SETS(NUM_SETS)
   ) u_set_map (
      .clock  (clock),
      .load   (accept),
      .set_raw(req_set_index),
      .set_idx(set_idx)
   );

   salr_row_ram #(
      .DEPTH(NUM_SETS),
      .WIDTH(ROW_W)
   ) u_row_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(set_idx),
      .rd_data(row_rd)
   );

   salr_row_logic #(
      .NUM_WAYS  (NUM_WAYS),
      .REUSE_BITS(REUSE_BITS)
   ) u_row_logic (
      .row_rd(row_rd),
      .op    (op_ff),
      .row_wr(row_wr),
      .upd_ok(upd_ok),
      .victim(victim)
   );

   // reset row: way w at position w, counts zero
   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         init_pos[w] = PW'(w);
      end
      init_row = {{(NUM_WAYS*REUSE_BITS){1'b0}}, init_pos};
   end

   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_cnt_ff : set_ff;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? init_row : row_wr;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      set_in       = set_ff;
      op_in        = op_ff;
      victim_in    = victim_ff;
      rsp_valid_in = rsp_busy;
      ram_we       = 1'b0;
      ram_rd_en    = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (clr_cnt_ff == SW'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in.is_update = (req_command == CMD_UPDATE);
               op_in.was_hit   = req_was_hit;
               op_in.way       = req_way_index;
               if (MAP_DIRECT) begin
                  ram_rd_en = 1'b1;
                  set_in    = set_idx;
                  state_in  = ST_EXEC;
               end else begin
                  state_in = ST_MAP;
               end
            end
         end
         ST_MAP: begin
            ram_rd_en = 1'b1;
            set_in    = set_idx;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            if (op_ff.is_update) begin
               ram_we   = upd_ok;
               state_in = ST_IDLE;
            end else if (!rsp_busy) begin
               rsp_valid_in = 1'b1;
               victim_in    = victim;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      set_ff    <= set_in;
      op_ff     <= op_in;
      victim_ff <= victim_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = victim_ff;

   // read and write-back of a row never share a cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_rd_en))
      else $error("row read and write in the same cycle");

   // a new victim word only comes out of the execute step
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == ST_EXEC))
      else $error("victim word raised outside execute");

   // updates never produce a word
   a_update_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && op_ff.is_update && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("update produced a victim word");

   // no item is taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!ram_rd_en && !rsp_valid_ff))
      else $error("activity during clearing pass");

endmodule

[bench/tb_set_assoc_lru_reuse_replacement.sv]
`timescale 1ns / 1ps
module tb_set_assoc_lru_reuse_replacement;
   import salr_pkg::*;

   localparam int NUM_SETS   = DEF_NUM_SETS;
   localparam int NUM_WAYS   = DEF_NUM_WAYS;
   localparam int REUSE_BITS = DEF_REUSE_BITS;
   localparam int N_DIR      = 20;
   localparam int N_SAT      = 280;
   localparam int N_RAND     = 1100;

   typedef struct packed {
      logic                 cmd;
      logic [SET_IDX_W-1:0] set_idx;
      logic [WAY_IDX_W-1:0] way;
      logic                 hit;
      logic                 typed;
      logic [WAY_IDX_W-1:0] victim;
   } dir_row_type;

   // typed rows carry their victim; the rest go through the predictor
   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      '{CMD_VICTIM, 11'd0,    4'd0,  1'b0, 1'b1, 4'd15},
      '{CMD_VICTIM, 11'd2047, 4'd0,  1'b0, 1'b1, 4'd15},
      '{CMD_VICTIM, 11'd1024, 4'd9,  1'b1, 1'b1, 4'd15},
      '{CMD_UPDATE, 11'd2047, 4'd15, 1'b1, 1'b0, 4'd0},
      '{CMD_UPDATE, 11'd2047, 4'd15, 1'b1, 1'b0, 4'd0},
      '{CMD_VICTIM, 11'd2047, 4'd0,  1'b0, 1'b0, 4'd0},
      '{CMD_UPDATE, 11'd2047, 4'd14, 1'b0, 1'b0, 4'd0},
      '{CMD_VICTIM, 11'd2047, 4'd0,  1'b0, 1'b0, 4'd0},
      '{CMD_UPDATE, 11'd0,    4'd0,  1'b0, 1'b0, 4'd0},
      '{CMD_UPDATE, 11'd0,    4'd15, 1'b1, 1'b0, 4'd0},
      '{CMD_VICTIM, 11'd0,    4'd0,  1'b0, 1'b0, 4'd0},
      '{CMD_UPDATE, 11'd2047, 4'd0,  1'b1, 1'b0, 4'd0},
      '{CMD_UPDATE, 11'd2047, 4'd13, 1'b1, 1'b0, 4'd0},
      '{CMD_VICTIM, 11'd2047, 4'd0,  1'b0, 1'b0, 4'd0},
      '{CMD_UPDATE, 11'd1,    4'd7,  1'b0, 1'b0, 4'd0},
      '{CMD_UPDATE, 11'd1,    4'd8,  1'b1, 1'b0, 4'd0},
      '{CMD_VICTIM, 11'd1,    4'd0,  1'b0, 1'b0, 4'd0},
      '{CMD_UPDATE, 11'd1,    4'd7,  1'b1, 1'b0, 4'd0},
      '{CMD_VICTIM, 11'd1,    4'd0,  1'b0, 1'b0, 4'd0},
      '{CMD_VICTIM, 11'd0,    4'd15, 1'b1, 1'b0, 4'd0}
   };

   localparam logic [SET_IDX_W-1:0] HOT_SETS [8] = '{
      11'd0, 11'd2047, 11'd1, 11'd1024, 11'd5, 11'd700, 11'd1500, 11'd2046
   };

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_command    = 1'b0;
   logic [SET_IDX_W-1:0] req_set_index  = '0;
   logic [WAY_IDX_W-1:0] req_way_index  = '0;
   logic                 req_was_hit    = 1'b0;
   logic                 rsp_ready      = 1'b0;
   logic                 req_ready;
   logic                 rsp_valid;
   logic [WAY_IDX_W-1:0] rsp_victim_way;

   set_assoc_lru_reuse_replacement uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_set_index  (req_set_index),
      .req_way_index  (req_way_index),
      .req_was_hit    (req_was_hit),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_victim_way (rsp_victim_way)
   );

   logic [WAY_IDX_W-1:0]  lru_pos   [NUM_SETS][NUM_WAYS];
   logic [REUSE_BITS-1:0] reuse_cnt [NUM_SETS][NUM_WAYS];
   logic [WAY_IDX_W-1:0]  pending_victims [$];
   logic [WAY_IDX_W-1:0]  want_way;
   int errors      = 0;
   int words_taken = 0;
   int burst_left  = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // oldest position wins; reuse count only breaks ties
   function automatic logic [WAY_IDX_W-1:0] pick_victim(int s);
      int best_w;
      best_w = 0;
      for (int w = 1; w < NUM_WAYS; w++)
         if (lru_pos[s][w] > lru_pos[s][best_w] ||
             (lru_pos[s][w] == lru_pos[s][best_w] &&
              reuse_cnt[s][w] < reuse_cnt[s][best_w]))
            best_w = w;
      return best_w[WAY_IDX_W-1:0];
   endfunction

   function automatic void touch_way(int s, int w, logic hit);
      logic [WAY_IDX_W-1:0] own;
      if (w >= NUM_WAYS) return;
      if (hit) begin
         if (reuse_cnt[s][w] != '1) reuse_cnt[s][w]++;
      end else begin
         reuse_cnt[s][w] = '0;
      end
      own = lru_pos[s][w];
      for (int v = 0; v < NUM_WAYS; v++)
         if (lru_pos[s][v] < own) lru_pos[s][v]++;
      lru_pos[s][w] = '0;
   endfunction

   task automatic send_word(input logic cmd, input logic [SET_IDX_W-1:0] s,
                            input logic [WAY_IDX_W-1:0] w, input logic hit,
                            input logic typed, input logic [WAY_IDX_W-1:0] typed_way);
      int si;
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_set_index <= s;
      req_way_index <= w;
      req_was_hit   <= hit;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      si = s % NUM_SETS;
      words_taken++;
      if (cmd == CMD_VICTIM)
         pending_victims.push_back(typed ? typed_way : pick_victim(si));
      else
         touch_way(si, w, hit);
      // sender pacing: bursts with optional gaps
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 23);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   task automatic random_word();
      logic [SET_IDX_W-1:0] s;
      logic                 cmd;
      logic                 hit;
      if ($urandom_range(0, 9) < 7) s = HOT_SETS[$urandom_range(0, 7)];
      else s = SET_IDX_W'($urandom_range(0, (1 << SET_IDX_W) - 1));
      cmd = ($urandom_range(0, 9) < 4) ? CMD_VICTIM : CMD_UPDATE;
      hit = ($urandom_range(0, 9) < 7);
      send_word(cmd, s, WAY_IDX_W'($urandom_range(0, (1 << WAY_IDX_W) - 1)), hit,
                1'b0, '0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_victims.size() == 0) begin
            errors++;
            $display("%0t: victim_way word, expected none, actual %0d",
                     $time, rsp_victim_way);
         end else begin
            want_way = pending_victims.pop_front();
            if (rsp_victim_way !== want_way) begin
               errors++;
               $display("%0t: victim_way mismatch, expected %0d, actual %0d",
                        $time, want_way, rsp_victim_way);
            end
         end
      end
   end

   initial begin
      int  cyc;
      bit  held;
      cyc  = 0;
      held = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         cyc++;
         if (!held && words_taken >= 400) begin
            // long hold-off so the block backs up into req_ready
            held = 1;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            case ((cyc / 97) % 4)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= (cyc % 5 == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      logic [SET_IDX_W-1:0] sat_set;
      logic [WAY_IDX_W-1:0] sat_way;
      for (int s = 0; s < NUM_SETS; s++)
         for (int w = 0; w < NUM_WAYS; w++) begin
            lru_pos[s][w]   = WAY_IDX_W'(w);
            reuse_cnt[s][w] = '0;
         end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIR; i++)
         send_word(DIR_ROWS[i].cmd, DIR_ROWS[i].set_idx, DIR_ROWS[i].way,
                   DIR_ROWS[i].hit, DIR_ROWS[i].typed, DIR_ROWS[i].victim);

      // hammer one way with hits until its reuse count saturates
      sat_set = HOT_SETS[$urandom_range(0, 7)];
      sat_way = WAY_IDX_W'($urandom_range(0, NUM_WAYS - 1));
      for (int i = 0; i < N_SAT; i++) begin
         if (i % 40 == 39) send_word(CMD_VICTIM, sat_set, '0, 1'b0, 1'b0, '0);
         else send_word(CMD_UPDATE, sat_set, sat_way, 1'b1, 1'b0, '0);
      end

      for (int i = 0; i < N_RAND; i++) random_word();
      req_valid <= 1'b0;

      while (pending_victims.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
